FILE: rtl/crast_pkg.sv
// ----------------------------------------------------------------------------
// Circle rasterizer package
// Field widths, register indexes, reset values and the structures that pass
// between the scan sequencer, the pixel datapath and the top level.
// ----------------------------------------------------------------------------
package crast_pkg;

   localparam int CENTER_W   = 12;
   localparam int RADIUS_W   = 11;
   localparam int COLOR_W    = 24;
   localparam int FRAME_W    = 13;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   // Offset i saturates one step past the largest radius; offset j never
   // passes the largest radius.
   localparam int OFF_I_W = RADIUS_W + 2;
   localparam int OFF_J_W = RADIUS_W + 1;
   localparam int SUM_W   = 2 * RADIUS_W + 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_RADIUS,
      CSR_FILL_MODE,
      CSR_DRAW_COLOR,
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [RADIUS_W-1:0] radius;
      logic                fill_mode;
      logic [COLOR_W-1:0]  draw_color;
      logic [FRAME_W-1:0]  frame_width;
      logic [FRAME_W-1:0]  frame_height;
   } crast_cfg_type;

   localparam crast_cfg_type CFG_RESET = '{
      center_x:     '0,
      center_y:     '0,
      radius:       RADIUS_W'(1),
      fill_mode:    1'b0,
      draw_color:   COLOR_W'(24'hFF_FFFF),
      frame_width:  FRAME_W'(640),
      frame_height: FRAME_W'(480)
   };

   typedef struct packed {
      logic                      point;
      logic                      last;
      logic signed [OFF_I_W-1:0] off_i;
      logic signed [OFF_J_W-1:0] off_j;
   } crast_pt_type;

endpackage

FILE: rtl/crast_if.sv
// ----------------------------------------------------------------------------
// Circle rasterizer channels
// Valid/ready channels for scan steps in and pixel writes out.
// ----------------------------------------------------------------------------
interface crast_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface crast_rsp_if
   import crast_pkg::*;
#(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic                  pixel_valid;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [COLOR_W-1:0]    pixel_color;
   logic                  scan_last;

   modport source (output valid, output pixel_valid, output pixel_x, output pixel_y,
                   output pixel_color, output scan_last, input ready);
   modport sink   (input valid, input pixel_valid, input pixel_x, input pixel_y,
                   input pixel_color, input scan_last, output ready);
endinterface

FILE: rtl/crast_scan.sv
// ----------------------------------------------------------------------------
// Circle rasterizer scan sequencer
// Holds the scan offsets, loads them on a restart transfer, steps them on every
// other transfer of an active scan and registers the resulting scan point for the pixel datapath.
// ----------------------------------------------------------------------------
module crast_scan
   import crast_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  crast_cfg_type cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          in_restart,
   output logic          pt_valid,
   output crast_pt_type  pt,
   input  logic          pt_take
);

   localparam logic signed [OFF_I_W-1:0] ONE_I = OFF_I_W'(1);
   localparam logic signed [OFF_J_W-1:0] ONE_J = OFF_J_W'(1);
   localparam logic signed [OFF_I_W-1:0] I_CAP = OFF_I_W'(2 ** RADIUS_W);

   logic signed [OFF_I_W-1:0] off_i_ff, off_i_in;
   logic signed [OFF_J_W-1:0] off_j_ff, off_j_in;
   logic                      active_ff, active_in;
   logic                      pt_valid_ff, pt_valid_in;
   crast_pt_type              pt_ff, pt_in;

   logic signed [OFF_I_W-1:0] radius_s;
   logic signed [OFF_I_W-1:0] lo;
   logic signed [OFF_I_W-1:0] hi;
   logic                      accept;
   logic                      point;
   logic                      last;

   assign radius_s = signed'(OFF_I_W'(cfg.radius));
   assign lo       = ONE_I - radius_s;
   assign hi       = radius_s - ONE_I;
   assign in_ready = !pt_valid_ff || pt_take;
   assign accept   = in_valid && in_ready;

   always_comb begin
      off_i_in    = off_i_ff;
      off_j_in    = off_j_ff;
      active_in   = active_ff;
      pt_valid_in = pt_valid_ff && !pt_take;
      pt_in       = pt_ff;
      point       = 1'b0;
      last        = 1'b0;
      if (accept) begin
         if (in_restart) begin
            if (cfg.radius == '0) begin
               active_in = 1'b0;
               off_i_in  = '0;
               off_j_in  = '0;
               last      = 1'b1;
            end else begin
               active_in = 1'b1;
               off_i_in  = lo;
               off_j_in  = lo[OFF_J_W-1:0];
               point     = 1'b1;
            end
         end else if (active_ff) begin
            point = 1'b1;
            if (OFF_I_W'(off_j_ff) >= hi) begin
               off_j_in = lo[OFF_J_W-1:0];
               off_i_in = (off_i_ff >= I_CAP) ? off_i_ff : off_i_ff + ONE_I;
            end else begin
               off_j_in = off_j_ff + ONE_J;
            end
         end
         if (point && off_i_in >= hi && OFF_I_W'(off_j_in) >= hi) begin
            last      = 1'b1;
            active_in = 1'b0;
         end
         pt_valid_in = 1'b1;
         pt_in       = '{point: point, last: last, off_i: off_i_in, off_j: off_j_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_i_ff    <= '0;
         off_j_ff    <= '0;
         active_ff   <= 1'b0;
         pt_valid_ff <= 1'b0;
      end else begin
         off_i_ff    <= off_i_in;
         off_j_ff    <= off_j_in;
         active_ff   <= active_in;
         pt_valid_ff <= pt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

   assign pt_valid = pt_valid_ff;
   assign pt       = pt_ff;

endmodule

FILE: rtl/crast_pix.sv
// ----------------------------------------------------------------------------
// Circle rasterizer pixel datapath
// Squares the offsets of the registered scan point, applies the disc, outline
// and frame tests and registers the pixel write.
// ----------------------------------------------------------------------------
module crast_pix
   import crast_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  crast_cfg_type         cfg,
   input  logic                  pt_valid,
   input  crast_pt_type          pt,
   output logic                  pt_take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  pixel_valid,
   output logic [COORD_BITS-1:0] pixel_x,
   output logic [COORD_BITS-1:0] pixel_y,
   output logic [COLOR_W-1:0]    pixel_color,
   output logic                  scan_last
);

   localparam int CMP_W = (COORD_BITS + 2 > OFF_I_W + 3) ? COORD_BITS + 2 : OFF_I_W + 3;
   localparam logic signed [CMP_W-1:0]   SPAN  = CMP_W'(2 ** COORD_BITS);
   localparam logic signed [SUM_W-1:0]   ONE_S = SUM_W'(1);
   localparam logic signed [OFF_I_W-1:0] ONE_I = OFF_I_W'(1);

   logic                  out_valid_ff, out_valid_in;
   logic                  pixel_valid_ff, pixel_valid_in;
   logic [COORD_BITS-1:0] pixel_x_ff, pixel_x_in;
   logic [COORD_BITS-1:0] pixel_y_ff, pixel_y_in;
   logic [COLOR_W-1:0]    pixel_color_ff, pixel_color_in;
   logic                  scan_last_ff, scan_last_in;

   logic                      adv_out;
   logic signed [CMP_W-1:0]   px_s;
   logic signed [CMP_W-1:0]   py_s;
   logic signed [CMP_W-1:0]   fw_s;
   logic signed [CMP_W-1:0]   fh_s;
   logic signed [SUM_W-1:0]   ext_i;
   logic signed [SUM_W-1:0]   ext_j;
   logic signed [SUM_W-1:0]   ext_r;
   logic signed [SUM_W-1:0]   sum_c;
   logic signed [SUM_W-1:0]   r_sq;
   logic signed [SUM_W-1:0]   two_i;
   logic signed [SUM_W-1:0]   two_j;
   logic signed [OFF_I_W-1:0] lo;
   logic                      in_frame;
   logic                      disc_hit;
   logic                      edge_pt;
   logic                      drawn;

   assign adv_out = !out_valid_ff || rsp_ready;
   assign pt_take = adv_out;

   // The first row and column of the disc are always part of the outline.
   always_comb begin
      px_s     = signed'(CMP_W'(cfg.center_x)) + CMP_W'(pt.off_i);
      py_s     = signed'(CMP_W'(cfg.center_y)) + CMP_W'(pt.off_j);
      fw_s     = signed'(CMP_W'(cfg.frame_width));
      fh_s     = signed'(CMP_W'(cfg.frame_height));
      in_frame = !px_s[CMP_W-1] && !py_s[CMP_W-1] &&
                 (px_s < fw_s) && (px_s < SPAN) &&
                 (py_s < fh_s) && (py_s < SPAN);

      ext_i    = SUM_W'(pt.off_i);
      ext_j    = SUM_W'(pt.off_j);
      ext_r    = signed'(SUM_W'(cfg.radius));
      sum_c    = ext_i * ext_i + ext_j * ext_j;
      r_sq     = ext_r * ext_r;
      two_i    = ext_i <<< 1;
      two_j    = ext_j <<< 1;
      lo       = ONE_I - signed'(OFF_I_W'(cfg.radius));
      disc_hit = sum_c <= r_sq;
      edge_pt  = (pt.off_i == lo) || (OFF_I_W'(pt.off_j) == lo) ||
                 (sum_c - two_i + ONE_S > r_sq) || (sum_c + two_i + ONE_S > r_sq) ||
                 (sum_c - two_j + ONE_S > r_sq) || (sum_c + two_j + ONE_S > r_sq);
      drawn    = pt.point && in_frame && disc_hit && (cfg.fill_mode || edge_pt);

      out_valid_in   = out_valid_ff;
      pixel_valid_in = pixel_valid_ff;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      pixel_color_in = pixel_color_ff;
      scan_last_in   = scan_last_ff;
      if (adv_out) begin
         out_valid_in   = pt_valid;
         pixel_valid_in = drawn;
         pixel_x_in     = drawn ? px_s[COORD_BITS-1:0] : '0;
         pixel_y_in     = drawn ? py_s[COORD_BITS-1:0] : '0;
         pixel_color_in = drawn ? cfg.draw_color : '0;
         scan_last_in   = pt.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_valid_ff <= pixel_valid_in;
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      pixel_color_ff <= pixel_color_in;
      scan_last_ff   <= scan_last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign pixel_valid = pixel_valid_ff;
   assign pixel_x     = pixel_x_ff;
   assign pixel_y     = pixel_y_ff;
   assign pixel_color = pixel_color_ff;
   assign scan_last   = scan_last_ff;

endmodule

FILE: rtl/circle_rasterizer.sv
// ----------------------------------------------------------------------------
// Circle rasterizer
//
// Channel  Direction  Handshake      Payload
// req_ch   in         valid/ready    restart
// rsp_ch   out        valid/ready    pixel_valid, pixel_x, pixel_y,
//                                    pixel_color, scan_last
// csr      in         csr_we         csr_index, csr_wdata
//
// One scan step is taken per cycle while rsp_ch does not stall. Its result
// passes two registers after the step transfer: the sequencer registers the
// scan point and the pixel logic feeds the output register.
// Reset clears the scan offsets and the valid flags and loads the reset configuration.
// A stalled result holds the output register; the sequencer register takes
// one more step behind it, after which req_ch stalls until rsp_ch transfers.
// ----------------------------------------------------------------------------
module circle_rasterizer
   import crast_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  logic                  clock,
   input  logic                  reset,
   crast_req_if.sink             req_ch,
   crast_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   crast_cfg_type cfg_ff, cfg_in;
   logic          pt_valid;
   crast_pt_type  pt;
   logic          pt_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:     cfg_in.center_x     = csr_wdata[CENTER_W-1:0];
            CSR_CENTER_Y:     cfg_in.center_y     = csr_wdata[CENTER_W-1:0];
            CSR_RADIUS:       cfg_in.radius       = csr_wdata[RADIUS_W-1:0];
            CSR_FILL_MODE:    cfg_in.fill_mode    = csr_wdata[0];
            CSR_DRAW_COLOR:   cfg_in.draw_color   = csr_wdata[COLOR_W-1:0];
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[FRAME_W-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[FRAME_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crast_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_restart (req_ch.restart),
      .pt_valid   (pt_valid),
      .pt         (pt),
      .pt_take    (pt_take)
   );

   crast_pix #(
      .COORD_BITS (COORD_BITS)
   ) u_pix (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pt_valid    (pt_valid),
      .pt          (pt),
      .pt_take     (pt_take),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .pixel_valid (rsp_ch.pixel_valid),
      .pixel_x     (rsp_ch.pixel_x),
      .pixel_y     (rsp_ch.pixel_y),
      .pixel_color (rsp_ch.pixel_color),
      .scan_last   (rsp_ch.scan_last)
   );

endmodule

FILE: rtl/crast_chk.sv
// ----------------------------------------------------------------------------
// Circle rasterizer checker
// Port-level assertions on the step and pixel channels, bound to the top.
// ----------------------------------------------------------------------------
module crast_chk
   import crast_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_pixel_valid,
   input logic [COORD_BITS-1:0] rsp_pixel_x,
   input logic [COORD_BITS-1:0] rsp_pixel_y,
   input logic [COLOR_W-1:0]    rsp_pixel_color,
   input logic                  rsp_scan_last
);

   // A point that is not written carries no coordinates or color.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |->
         rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_pixel_color == '0)
      else $error("undrawn point carries nonzero payload");

   // Nothing comes out of the pipeline in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

   // When the result side takes, the step side is never held off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("step channel stalled while results drain");

   // A stalled result keeps its contents until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pixel_valid) && $stable(rsp_pixel_x) &&
         $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_scan_last))
      else $error("stalled result changed");

   // A result that appears on an empty output follows a step transfer that
   // has passed the scan point register and then the output register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a step transfer");

endmodule

bind circle_rasterizer crast_chk #(
   .COORD_BITS (COORD_BITS)
) u_crast_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pixel_valid (rsp_ch.pixel_valid),
   .rsp_pixel_x     (rsp_ch.pixel_x),
   .rsp_pixel_y     (rsp_ch.pixel_y),
   .rsp_pixel_color (rsp_ch.pixel_color),
   .rsp_scan_last   (rsp_ch.scan_last)
);
